@@ src/dlm_pkg.sv @@
package dlm_pkg;

  // Value format and accumulator.
  localparam int DATA_WIDTH = 16;
  localparam int ACC_WIDTH  = 40;
  localparam int PROD_WIDTH = 2 * DATA_WIDTH;

  // Default store sizes.
  localparam int MAX_INPUTS  = 64;
  localparam int MAX_NEURONS = 64;

  // Port field widths.
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 7;
  localparam int FRAC_W = 4;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    OP_LOAD_WEIGHT  = 2'd0,
    OP_LOAD_BIAS    = 2'd1,
    OP_LOAD_FEATURE = 2'd2,
    OP_RUN          = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INPUT_COUNT  = 2'd0,
    CFG_NEURON_COUNT = 2'd1,
    CFG_RELU_ENABLE  = 2'd2,
    CFG_FRAC_BITS    = 2'd3
  } cfg_idx_t;

  // Commands from the sequencer to the MAC unit.
  typedef struct packed {
    logic issue;   // operands are being read this cycle
    logic first;   // first product of a neuron, starts from the bias
    logic round;   // register the rounded sum
  } mac_ctl_t;

endpackage

@@ src/dlm_ram.sv @@
module dlm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/dlm_mac.sv @@
module dlm_mac (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  dlm_pkg::mac_ctl_t                    ctl,
  input  logic [dlm_pkg::DATA_WIDTH-1:0]       feature_rd,
  input  logic [dlm_pkg::DATA_WIDTH-1:0]       weight_rd,
  input  logic [dlm_pkg::DATA_WIDTH-1:0]       bias_rd,
  input  logic [dlm_pkg::FRAC_W-1:0]           frac_bits,
  input  logic                                 relu_enable,
  output logic                                 busy,
  output logic signed [dlm_pkg::DATA_WIDTH-1:0] act
);

  localparam int DW  = dlm_pkg::DATA_WIDTH;
  localparam int AW  = dlm_pkg::ACC_WIDTH;
  localparam int PW  = dlm_pkg::PROD_WIDTH;
  localparam int RNW = AW + 1;

  localparam logic signed [RNW-1:0] SAT_HI = {{(RNW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [RNW-1:0] SAT_LO = {{(RNW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  logic                  v1_r, v2_r;
  logic                  first1_r, first2_r;
  logic signed [PW-1:0]  prod_r;
  logic signed [AW-1:0]  bias_q_r;
  logic signed [AW-1:0]  acc_r;
  logic signed [RNW-1:0] rnd_r;
  logic [RNW-1:0]        round_ofs;
  logic signed [RNW-1:0] shifted;

  assign busy = v1_r | v2_r;

  // Half of one output step, zero when there are no fraction bits.
  assign round_ofs = (RNW'(1) << frac_bits) >> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      first1_r <= 1'b0;
      first2_r <= 1'b0;
    end else begin
      v1_r     <= ctl.issue;
      v2_r     <= v1_r;
      first1_r <= ctl.first;
      first2_r <= first1_r;
    end
  end

  // Store read data arrives in the cycle after the address; the bias read
  // is taken together with the first product of its neuron.
  always_ff @(posedge clk) begin
    prod_r   <= $signed(feature_rd) * $signed(weight_rd);
    bias_q_r <= AW'($signed(bias_rd)) <<< frac_bits;
    if (v2_r) begin
      acc_r <= (first2_r ? bias_q_r : acc_r) + AW'(prod_r);
    end
    if (ctl.round) begin
      rnd_r <= $signed({acc_r[AW-1], acc_r}) + $signed(round_ofs);
    end
  end

  always_comb begin
    shifted = rnd_r >>> frac_bits;
    if (relu_enable && shifted[RNW-1]) begin
      act = '0;
    end else if (shifted > SAT_HI) begin
      act = SAT_HI[DW-1:0];
    end else if (shifted < SAT_LO) begin
      act = SAT_LO[DW-1:0];
    end else begin
      act = shifted[DW-1:0];
    end
  end

endmodule

@@ src/dlm_seq.sv @@
module dlm_seq #(
  parameter int MAX_INPUTS  = dlm_pkg::MAX_INPUTS,
  parameter int MAX_NEURONS = dlm_pkg::MAX_NEURONS,
  localparam int RW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1,
  localparam int NW  = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1,
  localparam int WAW = (MAX_INPUTS * MAX_NEURONS > 1) ?
                       $clog2(MAX_INPUTS * MAX_NEURONS) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [dlm_pkg::CNT_W-1:0]     input_count,
  input  logic [dlm_pkg::CNT_W-1:0]     neuron_count,
  input  logic                          mac_busy,
  input  logic                          out_free,
  output logic                          busy,
  output dlm_pkg::mac_ctl_t             ctl,
  output logic [RW-1:0]                 feat_addr,
  output logic [NW-1:0]                 bias_addr,
  output logic [WAW-1:0]                weight_addr,
  output logic                          out_load,
  output logic [dlm_pkg::IDX_W-1:0]     out_neuron,
  output logic                          out_last
);

  localparam int ICW = ($clog2(MAX_INPUTS + 1) > dlm_pkg::CNT_W) ?
                       $clog2(MAX_INPUTS + 1) : dlm_pkg::CNT_W;
  localparam int NCW = ($clog2(MAX_NEURONS + 1) > dlm_pkg::CNT_W) ?
                       $clog2(MAX_NEURONS + 1) : dlm_pkg::CNT_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_WAIT  = 5'b00100,
    S_ROUND = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t        state_r, state_nxt;
  logic [RW-1:0] r_r, r_nxt, r_last_r, r_last_nxt;
  logic [NW-1:0] n_r, n_nxt, n_last_r, n_last_nxt;
  logic [ICW-1:0] ic;
  logic [NCW-1:0] nc;
  logic [RW-1:0] r_last_cl;
  logic [NW-1:0] n_last_cl;

  // Counts of zero act as one, counts above the store size as the size.
  always_comb begin
    ic = ICW'(input_count);
    nc = NCW'(neuron_count);
    if (ic == '0) begin
      r_last_cl = '0;
    end else if (ic > ICW'(MAX_INPUTS)) begin
      r_last_cl = RW'(MAX_INPUTS - 1);
    end else begin
      r_last_cl = RW'(ic - ICW'(1));
    end
    if (nc == '0) begin
      n_last_cl = '0;
    end else if (nc > NCW'(MAX_NEURONS)) begin
      n_last_cl = NW'(MAX_NEURONS - 1);
    end else begin
      n_last_cl = NW'(nc - NCW'(1));
    end
  end

  always_comb begin
    state_nxt  = state_r;
    r_nxt      = r_r;
    n_nxt      = n_r;
    r_last_nxt = r_last_r;
    n_last_nxt = n_last_r;
    ctl        = '0;
    out_load   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          r_nxt      = '0;
          n_nxt      = '0;
          r_last_nxt = r_last_cl;
          n_last_nxt = n_last_cl;
          state_nxt  = S_ISSUE;
        end
      end
      S_ISSUE: begin
        ctl.issue = 1'b1;
        ctl.first = (r_r == '0);
        if (r_r == r_last_r) begin
          state_nxt = S_WAIT;
        end else begin
          r_nxt = r_r + RW'(1);
        end
      end
      S_WAIT: begin
        if (!mac_busy) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        ctl.round = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (n_r == n_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            n_nxt     = n_r + NW'(1);
            r_nxt     = '0;
            state_nxt = S_ISSUE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    r_r      <= r_nxt;
    n_r      <= n_nxt;
    r_last_r <= r_last_nxt;
    n_last_r <= n_last_nxt;
  end

  assign busy        = (state_r != S_IDLE);
  assign feat_addr   = r_r;
  assign bias_addr   = n_r;
  assign weight_addr = WAW'(r_r) * WAW'(MAX_NEURONS) + WAW'(n_r);
  assign out_neuron  = dlm_pkg::IDX_W'(n_r);
  assign out_last    = (n_r == n_last_r);

endmodule

@@ src/dense_layer_mac_relu_top.sv @@
// Fully connected layer with optional ReLU on signed fixed point values.
// Load words (weight, bias, feature) are written into on-chip stores and
// are accepted whenever in_stall is low. A run word produces one activation
// word per neuron, in index order, with last set on the final one. All
// products go through a single 16x16 multiply-accumulate unit, one weight
// per cycle, and a run holds in_stall high until its last word is loaded;
// after the products of each neuron come the store read and multiply
// pipeline drain, rounding and the output load, which waits on out_stall.
// Configuration should be written only while no run is in progress.
module dense_layer_mac_relu_top #(
  parameter int MAX_INPUTS  = dlm_pkg::MAX_INPUTS,
  parameter int MAX_NEURONS = dlm_pkg::MAX_NEURONS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             in_operation,
  input  logic [dlm_pkg::IDX_W-1:0]              in_row_index,
  input  logic [dlm_pkg::IDX_W-1:0]              in_col_index,
  input  logic signed [dlm_pkg::DATA_WIDTH-1:0]  in_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [dlm_pkg::IDX_W-1:0]              out_neuron_index,
  output logic signed [dlm_pkg::DATA_WIDTH-1:0]  out_activation,
  output logic                                   out_last,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [dlm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [dlm_pkg::CNT_W-1:0]              cfg_data
);

  localparam int DW  = dlm_pkg::DATA_WIDTH;
  localparam int RW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int NW  = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
  localparam int WAW = (MAX_INPUTS * MAX_NEURONS > 1) ?
                       $clog2(MAX_INPUTS * MAX_NEURONS) : 1;

  logic [dlm_pkg::CNT_W-1:0]  input_count_r, neuron_count_r;
  logic                       relu_enable_r;
  logic [dlm_pkg::FRAC_W-1:0] frac_bits_r;

  logic           in_acc;
  logic           row_ok, col_ok;
  logic           we_weight, we_bias, we_feature, start;
  logic [WAW-1:0] w_waddr;

  logic              seq_busy, mac_busy, out_free, out_load, seq_last;
  dlm_pkg::mac_ctl_t mac_ctl;
  logic [RW-1:0]     feat_addr;
  logic [NW-1:0]     bias_addr;
  logic [WAW-1:0]    weight_addr;
  logic [dlm_pkg::IDX_W-1:0] seq_neuron;
  logic [DW-1:0]     feature_rd, weight_rd, bias_rd;
  logic signed [DW-1:0] act;

  logic                      out_valid_r;
  logic [dlm_pkg::IDX_W-1:0] out_neuron_r;
  logic signed [DW-1:0]      out_act_r;
  logic                      out_last_r;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_count_r  <= dlm_pkg::CNT_W'(64);
      neuron_count_r <= dlm_pkg::CNT_W'(64);
      relu_enable_r  <= 1'b1;
      frac_bits_r    <= dlm_pkg::FRAC_W'(12);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dlm_pkg::CFG_INPUT_COUNT:  input_count_r  <= cfg_data;
        dlm_pkg::CFG_NEURON_COUNT: neuron_count_r <= cfg_data;
        dlm_pkg::CFG_RELU_ENABLE:  relu_enable_r  <= cfg_data[0];
        dlm_pkg::CFG_FRAC_BITS:    frac_bits_r    <= cfg_data[dlm_pkg::FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  // Input words: loads go straight into the stores, a run starts the sequencer.
  assign in_stall = seq_busy;
  assign in_acc   = in_valid && !in_stall;
  assign row_ok   = int'(in_row_index) < MAX_INPUTS;
  assign col_ok   = int'(in_col_index) < MAX_NEURONS;

  assign we_weight  = in_acc && (in_operation == dlm_pkg::OP_LOAD_WEIGHT) && row_ok && col_ok;
  assign we_bias    = in_acc && (in_operation == dlm_pkg::OP_LOAD_BIAS) && col_ok;
  assign we_feature = in_acc && (in_operation == dlm_pkg::OP_LOAD_FEATURE) && row_ok;
  assign start      = in_acc && (in_operation == dlm_pkg::OP_RUN);

  assign w_waddr = WAW'(in_row_index) * WAW'(MAX_NEURONS) + WAW'(in_col_index);

  dlm_ram #(.WIDTH(DW), .DEPTH(MAX_INPUTS * MAX_NEURONS)) u_weight_ram (
    .clk   (clk),
    .we    (we_weight),
    .waddr (w_waddr),
    .wdata (in_value),
    .raddr (weight_addr),
    .rdata (weight_rd)
  );

  dlm_ram #(.WIDTH(DW), .DEPTH(MAX_NEURONS)) u_bias_ram (
    .clk   (clk),
    .we    (we_bias),
    .waddr (NW'(in_col_index)),
    .wdata (in_value),
    .raddr (bias_addr),
    .rdata (bias_rd)
  );

  dlm_ram #(.WIDTH(DW), .DEPTH(MAX_INPUTS)) u_feature_ram (
    .clk   (clk),
    .we    (we_feature),
    .waddr (RW'(in_row_index)),
    .wdata (in_value),
    .raddr (feat_addr),
    .rdata (feature_rd)
  );

  dlm_seq #(.MAX_INPUTS(MAX_INPUTS), .MAX_NEURONS(MAX_NEURONS)) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .input_count  (input_count_r),
    .neuron_count (neuron_count_r),
    .mac_busy     (mac_busy),
    .out_free     (out_free),
    .busy         (seq_busy),
    .ctl          (mac_ctl),
    .feat_addr    (feat_addr),
    .bias_addr    (bias_addr),
    .weight_addr  (weight_addr),
    .out_load     (out_load),
    .out_neuron   (seq_neuron),
    .out_last     (seq_last)
  );

  dlm_mac u_mac (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (mac_ctl),
    .feature_rd  (feature_rd),
    .weight_rd   (weight_rd),
    .bias_rd     (bias_rd),
    .frac_bits   (frac_bits_r),
    .relu_enable (relu_enable_r),
    .busy        (mac_busy),
    .act         (act)
  );

  // Output register; a new word may be loaded in the cycle the old one leaves.
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_neuron_r <= seq_neuron;
      out_act_r    <= act;
      out_last_r   <= seq_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_neuron_index = out_neuron_r;
  assign out_activation   = out_act_r;
  assign out_last         = out_last_r;

endmodule
